/* hw/rtl/dws_pkg.sv */
// Shared types and codes for the double-ended queue with search.
// Used by the cells, the result collector, the top level and the checker.
`default_nettype none

package dws_pkg;

	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 3;
	localparam int FILL_W   = 5;
	localparam int GROUP_N  = 32;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

	// Operation broadcast to every cell; flags are already qualified
	// by request acceptance and by full/empty.
	typedef struct packed {
		logic              push_front;
		logic              push_back;
		logic              pop_front;
		logic              pop_back;
		logic              search;
		logic [DATA_W-1:0] value;
	} ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/dws_cell.sv */
// One storage cell of the queue: holds the entry at a fixed position from the front.
// Depends on dws_pkg (ctrl_t, DATA_W).
`default_nettype none

module dws_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  wire logic                      clk,
	input  wire dws_pkg::ctrl_t            ctrl,
	input  wire logic [CW-1:0]             count,
	input  wire logic [dws_pkg::DATA_W-1:0] prev_data,
	input  wire logic [dws_pkg::DATA_W-1:0] next_data,
	output logic      [dws_pkg::DATA_W-1:0] data_q,
	output logic      [dws_pkg::DATA_W-1:0] rd_s1,
	output logic                            hit_s1
);

	logic held;
	logic is_tail_slot;
	logic is_last;

	assign held         = CW'(IDX) < count;
	assign is_tail_slot = CW'(IDX) == count;
	assign is_last      = CW'(IDX + 1) == count;

	always_ff @(posedge clk) begin
		if (ctrl.push_front) begin
			data_q <= prev_data;
		end else if (ctrl.push_back && is_tail_slot) begin
			data_q <= ctrl.value;
		end else if (ctrl.pop_front) begin
			data_q <= next_data;
		end
	end

	// only one cell drives nonzero read data, so the collector can OR
	always_ff @(posedge clk) begin
		if ((ctrl.pop_front && IDX == 0) || (ctrl.pop_back && is_last)) begin
			rd_s1 <= data_q;
		end else begin
			rd_s1 <= '0;
		end
		hit_s1 <= ctrl.search && held && (data_q == ctrl.value);
	end

endmodule

`default_nettype wire

/* hw/rtl/dws_reduce.sv */
// Two-level OR collector for the cell outputs: registered groups, then a final OR.
// Depends on dws_pkg (DATA_W, GROUP_N).
`default_nettype none

module dws_reduce #(
	parameter int N = 16
) (
	input  wire logic                                clk,
	input  wire logic [N-1:0]                        hit,
	input  wire logic [N-1:0][dws_pkg::DATA_W-1:0]   rd,
	output logic                                     any_hit,
	output logic      [dws_pkg::DATA_W-1:0]          any_data
);

	localparam int NG = (N + dws_pkg::GROUP_N - 1) / dws_pkg::GROUP_N;
	localparam int NP = NG * dws_pkg::GROUP_N;

	logic [NP-1:0]                       hit_pad;
	logic [NP-1:0][dws_pkg::DATA_W-1:0]  rd_pad;
	logic [NG-1:0]                       grp_hit_s2;
	logic [NG-1:0][dws_pkg::DATA_W-1:0]  grp_data_s2;

	assign hit_pad = NP'(hit);

	always_comb begin
		rd_pad = '0;
		rd_pad[N-1:0] = rd;
	end

	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic [dws_pkg::DATA_W-1:0] grp_data;

		always_comb begin
			grp_data = '0;
			for (int j = 0; j < dws_pkg::GROUP_N; j++) begin
				grp_data = grp_data | rd_pad[g*dws_pkg::GROUP_N + j];
			end
		end

		always_ff @(posedge clk) begin
			grp_hit_s2[g]  <= |hit_pad[g*dws_pkg::GROUP_N +: dws_pkg::GROUP_N];
			grp_data_s2[g] <= grp_data;
		end
	end

	always_comb begin
		any_hit  = |grp_hit_s2;
		any_data = '0;
		for (int g = 0; g < NG; g++) begin
			any_data = any_data | grp_data_s2[g];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/deque_with_search_core.sv */
// Bounded double-ended queue with search, built as a row of shifting cells.
// Depends on dws_pkg, dws_cell and dws_reduce.
// Result: an accepted request passes the cell read-out registers and the registered group
// OR that collect the popped value and the search hits, then shows its result with done high.
// busy covers both of those registers, so a new request is taken only once the last has left them.
// Reset: arst_n clears the count, the stage valid flags and done; cell contents are not cleared.
`default_nettype none

module deque_with_search_core #(
	parameter int CAPACITY = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic        [dws_pkg::KIND_W-1:0] kind,
	input  wire logic signed [dws_pkg::DATA_W-1:0] value,
	output logic                                   done,
	output logic             [dws_pkg::STATUS_W-1:0] status,
	output logic signed      [dws_pkg::DATA_W-1:0] popped_value,
	output logic             [dws_pkg::FILL_W-1:0] fill_count
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0] count_q;
	logic          full;
	logic          empty;
	logic          accept;

	dws_pkg::ctrl_t ctrl;
	logic [CW-1:0]  count_next;
	logic [dws_pkg::STATUS_W-1:0] status_next;

	logic                             valid_s1, valid_s2;
	logic                             search_s1, search_s2;
	logic [dws_pkg::STATUS_W-1:0]     status_s1, status_s2;
	logic [CW-1:0]                    count_s1, count_s2;

	logic [CAPACITY-1:0][dws_pkg::DATA_W-1:0] cell_data;
	logic [CAPACITY-1:0][dws_pkg::DATA_W-1:0] cell_rd;
	logic [CAPACITY-1:0]                      cell_hit;
	logic                                     any_hit;
	logic [dws_pkg::DATA_W-1:0]               any_data;

	assign full   = count_q == CW'(CAPACITY);
	assign empty  = count_q == '0;
	assign busy   = valid_s1 | valid_s2;
	assign accept = start && !busy;

	always_comb begin
		ctrl        = '0;
		ctrl.value  = value;
		count_next  = count_q;
		status_next = dws_pkg::ST_DONE;
		case (kind)
			dws_pkg::KIND_PUSH_FRONT: begin
				if (full) begin
					status_next = dws_pkg::ST_FULL;
				end else begin
					ctrl.push_front = accept;
					count_next      = count_q + 1'b1;
				end
			end
			dws_pkg::KIND_PUSH_BACK: begin
				if (full) begin
					status_next = dws_pkg::ST_FULL;
				end else begin
					ctrl.push_back = accept;
					count_next     = count_q + 1'b1;
				end
			end
			dws_pkg::KIND_POP_FRONT: begin
				if (empty) begin
					status_next = dws_pkg::ST_EMPTY;
				end else begin
					ctrl.pop_front = accept;
					count_next     = count_q - 1'b1;
				end
			end
			dws_pkg::KIND_POP_BACK: begin
				if (empty) begin
					status_next = dws_pkg::ST_EMPTY;
				end else begin
					ctrl.pop_back = accept;
					count_next    = count_q - 1'b1;
				end
			end
			dws_pkg::KIND_SEARCH: begin
				ctrl.search = accept;
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [dws_pkg::DATA_W-1:0] prev_d;
		logic [dws_pkg::DATA_W-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_d = value;
		end else begin : g_mid_l
			assign prev_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_d = cell_data[i];
		end else begin : g_mid_r
			assign next_d = cell_data[i+1];
		end

		dws_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.count     (count_q),
			.prev_data (prev_d),
			.next_data (next_d),
			.data_q    (cell_data[i]),
			.rd_s1     (cell_rd[i]),
			.hit_s1    (cell_hit[i])
		);
	end

	dws_reduce #(
		.N (CAPACITY)
	) u_reduce (
		.clk      (clk),
		.hit      (cell_hit),
		.rd       (cell_rd),
		.any_hit  (any_hit),
		.any_data (any_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			done     <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			done     <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			search_s1 <= kind == dws_pkg::KIND_SEARCH;
			status_s1 <= status_next;
			count_s1  <= count_next;
		end
		search_s2 <= search_s1;
		status_s2 <= status_s1;
		count_s2  <= count_s1;
		if (valid_s2) begin
			if (search_s2) begin
				status <= any_hit ? dws_pkg::ST_FOUND : dws_pkg::ST_NOT_FOUND;
			end else begin
				status <= status_s2;
			end
			popped_value <= any_data;
			fill_count   <= dws_pkg::FILL_W'(count_s2);
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/dws_check.sv */
// Port-level checker for deque_with_search_core, attached with bind.
// Depends on dws_pkg (status codes and field widths).
`default_nettype none

module dws_check #(
	parameter int CAPACITY = 16
) (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic        [dws_pkg::STATUS_W-1:0] status,
	input wire logic signed [dws_pkg::DATA_W-1:0]   popped_value,
	input wire logic        [dws_pkg::FILL_W-1:0]   fill_count
);

	logic req;
	assign req = start && !busy;

	// every accepted request is followed by the done strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##3 done)
		else $error("result strobe missing three cycles after request");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> !done ##1 !done)
		else $error("result strobe too early");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == dws_pkg::ST_EMPTY) |-> (fill_count == '0 && popped_value == '0))
		else $error("empty status with nonzero count or data");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == dws_pkg::ST_FULL) |->
			(fill_count == dws_pkg::FILL_W'(CAPACITY) && popped_value == '0))
		else $error("full status with wrong count or data");

	a_search_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == dws_pkg::ST_FOUND || status == dws_pkg::ST_NOT_FOUND)) |->
			popped_value == '0)
		else $error("search returned pop data");

endmodule

bind deque_with_search_core dws_check #(
	.CAPACITY (CAPACITY)
) u_dws_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.popped_value (popped_value),
	.fill_count   (fill_count)
);

`default_nettype wire
